### sv/vtr_pkg.sv
// Shared types and constants for the vote tally ranker.
// Used by vtr_table and vote_tally_ranker; no dependencies.
package vtr_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 16;
  localparam int VOTE_W      = 16;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  fill_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [VOTE_W-1:0] vcount_t;

  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_VOTE     = 2'd1;
  localparam logic [1:0] ACT_FINISH   = 2'd2;

  localparam vcount_t COUNT_MAX = {VOTE_W{1'b1}};

  // Access request to the candidate table
  typedef struct packed {
    idx_t    raddr;
    logic    we_key;
    logic    we_cnt;
    idx_t    waddr;
    key_t    wkey;
    vcount_t wcnt;
  } tbl_req_t;

  // Registered read data from the candidate table
  typedef struct packed {
    key_t    key;
    vcount_t cnt;
  } tbl_rd_t;

endpackage

### sv/vtr_table.sv
// Candidate table: identifier and vote count memories, one write and one
// registered read per cycle. Depends on vtr_pkg.
module vtr_table (
  input  logic             clk,
  input  vtr_pkg::tbl_req_t req,
  output vtr_pkg::tbl_rd_t  rd
);

  vtr_pkg::key_t    key_mem [vtr_pkg::MAX_ENTRIES];
  vtr_pkg::vcount_t cnt_mem [vtr_pkg::MAX_ENTRIES];

  // Write either field of the addressed entry
  always_ff @(posedge clk) begin
    if (req.we_key) begin
      key_mem[req.waddr] <= req.wkey;
    end
    if (req.we_cnt) begin
      cnt_mem[req.waddr] <= req.wcnt;
    end
  end

  // Read both fields into registered outputs
  always_ff @(posedge clk) begin
    rd.key <= key_mem[req.raddr];
    rd.cnt <= cnt_mem[req.raddr];
  end

endmodule

### sv/vote_tally_ranker.sv
// Vote tally ranker: one word in flight at a time; in_ready is high only when idle.
// A register is written in its accepting cycle; a vote is accepted and then reads the n entries in use,
// one table read per cycle, and ends when the read data for the last entry returns.
// Finish runs, per rank, a read pass over the entries in use and an emit step that
// waits while the output word is not taken.
// Reset (synchronous, rst_n low) empties the table; no clearing pass is needed.
module vote_tally_ranker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic [vtr_pkg::KEY_W-1:0]  in_cand_key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [vtr_pkg::KEY_W-1:0]  out_ranked_key,
  output logic [vtr_pkg::VOTE_W-1:0] out_ranked_count,
  output logic                    out_last_rank
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_VOTE = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  vtr_pkg::fill_t                  used_r, used_nxt;
  vtr_pkg::fill_t                  ptr_r, ptr_nxt;
  logic                            rd_vld_r;
  vtr_pkg::idx_t                   rd_idx_r;
  vtr_pkg::key_t                   key_r, key_nxt;
  logic [vtr_pkg::MAX_ENTRIES-1:0] taken_r, taken_nxt;
  logic                            found_r, found_nxt;
  vtr_pkg::idx_t                   best_idx_r, best_idx_nxt;
  vtr_pkg::key_t                   best_key_r, best_key_nxt;
  vtr_pkg::vcount_t                best_cnt_r, best_cnt_nxt;
  vtr_pkg::idx_t                   rank_r, rank_nxt;
  logic                            out_valid_r, out_valid_nxt;
  vtr_pkg::key_t                   out_key_r, out_key_nxt;
  vtr_pkg::vcount_t                out_cnt_r, out_cnt_nxt;
  logic                            out_last_r, out_last_nxt;

  vtr_pkg::tbl_req_t req;
  vtr_pkg::tbl_rd_t  rd;
  logic              issue;
  vtr_pkg::fill_t    used_m1;
  vtr_pkg::idx_t     last_idx;
  logic              beats;

  vtr_table u_table (
    .clk (clk),
    .req (req),
    .rd  (rd)
  );

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_ranked_key   = out_key_r;
  assign out_ranked_count = out_cnt_r;
  assign out_last_rank    = out_last_r;

  assign issue    = ((state_r == ST_VOTE) || (state_r == ST_SCAN)) && (ptr_r < used_r);
  assign used_m1  = vtr_pkg::fill_t'(used_r - 1'b1);
  assign last_idx = used_m1[vtr_pkg::IDX_W-1:0];

  // Rank order: higher count first, lower identifier on ties
  assign beats = !found_r || (rd.cnt > best_cnt_r) ||
                 ((rd.cnt == best_cnt_r) && (rd.key < best_key_r));

  // Sequence table walks, update counts and pick ranked entries
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    ptr_nxt       = ptr_r;
    key_nxt       = key_r;
    taken_nxt     = taken_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_key_nxt  = best_key_r;
    best_cnt_nxt  = best_cnt_r;
    rank_nxt      = rank_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;

    req.raddr  = ptr_r[vtr_pkg::IDX_W-1:0];
    req.we_key = 1'b0;
    req.we_cnt = 1'b0;
    req.waddr  = rd_idx_r;
    req.wkey   = key_r;
    req.wcnt   = vtr_pkg::vcount_t'(rd.cnt + 1'b1);

    if (issue) begin
      ptr_nxt = vtr_pkg::fill_t'(ptr_r + 1'b1);
    end

    // Drop the output word once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            vtr_pkg::ACT_REGISTER: begin
              if (used_r < vtr_pkg::fill_t'(vtr_pkg::MAX_ENTRIES)) begin
                req.we_key = 1'b1;
                req.we_cnt = 1'b1;
                req.waddr  = used_r[vtr_pkg::IDX_W-1:0];
                req.wkey   = in_cand_key;
                req.wcnt   = '0;
                used_nxt   = vtr_pkg::fill_t'(used_r + 1'b1);
              end
            end
            vtr_pkg::ACT_VOTE: begin
              if (used_r != '0) begin
                key_nxt   = in_cand_key;
                ptr_nxt   = '0;
                state_nxt = ST_VOTE;
              end
            end
            vtr_pkg::ACT_FINISH: begin
              if (used_r != '0) begin
                ptr_nxt   = '0;
                found_nxt = 1'b0;
                rank_nxt  = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_VOTE: begin
        if (rd_vld_r) begin
          if ((rd.key == key_r) && (rd.cnt != vtr_pkg::COUNT_MAX)) begin
            req.we_cnt = 1'b1;
          end
          if (rd_idx_r == last_idx) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (rd_vld_r) begin
          if (!taken_r[rd_idx_r] && beats) begin
            found_nxt    = 1'b1;
            best_idx_nxt = rd_idx_r;
            best_key_nxt = rd.key;
            best_cnt_nxt = rd.cnt;
          end
          if (rd_idx_r == last_idx) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_key_nxt           = best_key_r;
          out_cnt_nxt           = best_cnt_r;
          out_last_nxt          = (rank_r == last_idx);
          taken_nxt[best_idx_r] = 1'b1;
          if (rank_r == last_idx) begin
            used_nxt  = '0;
            taken_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            rank_nxt  = vtr_pkg::idx_t'(rank_r + 1'b1);
            ptr_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      taken_r     <= '0;
      found_r     <= 1'b0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ptr_r       <= ptr_nxt;
      rd_vld_r    <= issue;
      taken_r     <= taken_nxt;
      found_r     <= found_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= ptr_r[vtr_pkg::IDX_W-1:0];
    key_r      <= key_nxt;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
    best_cnt_r <= best_cnt_nxt;
    out_key_r  <= out_key_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  // Returned reads always lie inside the filled part of the table
  a_read_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (vtr_pkg::fill_t'(rd_idx_r) < used_r))
    else $error("table read beyond fill count");

  // A ranking pass never writes the table
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !(req.we_cnt || req.we_key))
    else $error("table written during ranking pass");

  // Every ranking pass ends with a chosen entry
  a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> found_r)
    else $error("emit without a chosen entry");

  // The last ranked word empties the table
  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && (state_nxt == ST_IDLE)) |=> (used_r == '0))
    else $error("table not emptied after last rank");
`endif

endmodule
